>>> hw/rtl/per_pkg.sv
// ----------------------------------------------------------------------------
// per_pkg
// Types and constants shared by the pulse event record parser and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package per_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_GATE   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_TOO_LONG     = 2'd0,
    ERR_SAMPLE_COUNT = 2'd1,
    ERR_MODULE       = 2'd2,
    ERR_TOO_SHORT    = 2'd3
  } err_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULE_ID    = 2'd0;
  localparam logic [1:0] CFG_PS_PER_CLOCK = 2'd1;
  localparam logic [1:0] CFG_CFD_FORMAT   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration reset values
  localparam logic [3:0]  MODULE_ID_RST    = 4'd0;
  localparam logic [14:0] PS_PER_CLOCK_RST = 15'd10000;
  localparam logic        CFD_FORMAT_RST   = 1'b1;

  // Timestamp clock period that doubles the raw clock
  localparam logic [14:0] PS_DOUBLE_CLOCK = 15'd4000;

  // Fixed positions inside a channel record
  localparam logic [13:0] GATE_FIRST_WORD  = 14'd3;
  localparam logic [4:0]  GATE_HEADER_LEN  = 5'd11;
  localparam logic [3:0]  SLOT_OFFSET      = 4'd2;
  localparam int unsigned SummedHeaderLen  = 4;
  localparam int unsigned ChannelRecords   = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        last_in_packet;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [48:0] raw_clock;
    logic [63:0] time_ps;
    logic [14:0] energy;
    logic [1:0]  pileup;
    logic [15:0] cfd_raw;
    logic [1:0]  sub_channel;
    logic [12:0] item_index;
    logic [31:0] payload;
    err_e        error_code;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/per_if.sv
// ----------------------------------------------------------------------------
// per_if
// Valid/ready channel interfaces for the parser's input words, results and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface per_in_if
  import per_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface per_out_if
  import per_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface per_cfg_if
  import per_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pulse_event_record_parser.sv
// ----------------------------------------------------------------------------
// pulse_event_record_parser
// Decodes a digitizer event word stream into hit records, gate words, sample
// pairs and errors.
// ----------------------------------------------------------------------------
// Takes one 32-bit word per clock and produces at most one result per word,
// in the cycle after the word is taken, from a single output register; a new
// word is taken in every cycle that the output register is empty or being
// drained. The hit record is emitted on the fifth event word; its time in
// picoseconds uses partial products of the timestamp and ps_per_clock that
// are registered while the fourth header word arrives, so the 64-bit time
// costs one three-input add on the fifth word. Channel record offset and
// record number are tracked by counters rather than division. After a size,
// too-short, sample-count or module error the rest of the packet is dropped silently.
// Configuration is written through its own channel, always ready, and must
// only change while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_event_record_parser
  import per_pkg::*;
#(
  parameter int unsigned MAX_EVENT_WORDS  = 5000,
  parameter int unsigned GATES_PER_RECORD = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  per_in_if.sink     in_i,
  per_out_if.source  out_o,
  per_cfg_if.sink    cfg_i
);

  localparam int unsigned PosW = $clog2(MAX_EVENT_WORDS + 1);
  localparam logic [16:0] MaxWords = 17'(MAX_EVENT_WORDS);
  localparam logic [13:0] GateEnd  = GATE_FIRST_WORD + 14'(GATES_PER_RECORD);
  localparam logic [2:0]  RecCount = 3'(ChannelRecords);
  localparam logic [PosW-1:0] FirstRecWord = PosW'(SummedHeaderLen);

  // Configuration registers
  logic [3:0]  module_id_q;
  logic [14:0] ps_per_clock_q;
  logic        cfd_format_q;

  // Parser state
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] total_q, total_d;
  logic [13:0]     elen_q, elen_d;
  logic [4:0]      hlen_q, hlen_d;
  logic [13:0]     roff_q, roff_d;
  logic [2:0]      rec_q, rec_d;
  logic            disc_q, disc_d;
  logic [31:0]     fw_q [SummedHeaderLen];

  // Time partial products
  logic [46:0] lo_prod_q;
  logic [31:0] hi_prod_q;
  logic [30:0] fine_prod_q;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic accept;
  logic in_ready;

  // Header decode
  logic [48:0] raw;
  logic [15:0] cfd;
  logic [15:0] fine;
  logic [63:0] time_ps;
  logic [13:0] blen, elen_w;
  logic [4:0]  hlen_w;
  logic [16:0] total_w;
  logic [3:0]  slot;
  logic [PosW:0] pos_inc;
  logic [13:0]   roff_inc;

  assign in_ready     = !out_valid_q || out_o.ready;
  assign in_i.ready   = in_ready;
  assign accept       = in_i.valid && in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.payload = out_q;
  assign cfg_i.ready  = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_id_q    <= MODULE_ID_RST;
      ps_per_clock_q <= PS_PER_CLOCK_RST;
      cfd_format_q   <= CFD_FORMAT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CFG_MODULE_ID:    module_id_q    <= cfg_i.payload.data[3:0];
        CFG_PS_PER_CLOCK: ps_per_clock_q <= cfg_i.payload.data[14:0];
        CFG_CFD_FORMAT:   cfd_format_q   <= cfg_i.payload.data[0];
        default: ;
      endcase
    end
  end

  // Build raw clock and CFD fraction from the stored header words
  always_comb begin
    if (ps_per_clock_q == PS_DOUBLE_CLOCK) begin
      raw = {fw_q[2][15:0], fw_q[1], 1'b0};
    end else begin
      raw = {1'b0, fw_q[2][15:0], fw_q[1]};
    end
    if (cfd_format_q) begin
      cfd = {1'b0, fw_q[2][30:16]};
    end else begin
      cfd = fw_q[2][31:16];
    end
  end

  // Register partial products of the time every cycle
  always_ff @(posedge clk_i) begin
    lo_prod_q   <= raw[31:0] * ps_per_clock_q;
    hi_prod_q   <= raw[48:32] * ps_per_clock_q;
    fine_prod_q <= cfd * ps_per_clock_q;
  end

  assign fine    = cfd_format_q ? fine_prod_q[30:15] : {1'b0, fine_prod_q[30:16]};
  assign time_ps = {hi_prod_q, 32'd0} + {17'd0, lo_prod_q} + {48'd0, fine};

  // Field extracts of the summed header and the first record word
  assign blen    = fw_q[0][30:17];
  assign elen_w  = in_i.payload.word[30:17];
  assign hlen_w  = in_i.payload.word[16:12];
  assign total_w = {3'd0, blen} + {1'b0, elen_w, 2'b00};
  assign slot    = fw_q[0][7:4];
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign roff_inc = roff_q + 14'd1;

  // Next state and result
  always_comb begin
    pos_d       = pos_q;
    total_d     = total_q;
    elen_d      = elen_q;
    hlen_d      = hlen_q;
    roff_d      = roff_q;
    rec_d       = rec_q;
    disc_d      = disc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    if (accept) begin
      out_valid_d = 1'b0;
      out_d       = '0;
      if (disc_q) begin
        // drop words until the packet ends
        if (in_i.payload.last_in_packet) begin
          disc_d = 1'b0;
          pos_d  = '0;
        end
      end else if (pos_q < FirstRecWord) begin
        pos_d = pos_q + 1'b1;
      end else if (pos_q == FirstRecWord) begin
        // check the event and emit the hit record or an error
        out_valid_d = 1'b1;
        pos_d       = '0;
        disc_d      = !in_i.payload.last_in_packet;
        out_d.kind  = KIND_ERROR;
        if (total_w > MaxWords) begin
          out_d.error_code = ERR_TOO_LONG;
        end else if (blen < 14'(SummedHeaderLen) || elen_w == '0 || hlen_w == '0) begin
          out_d.error_code = ERR_TOO_SHORT;
        end else if (slot < SLOT_OFFSET || (slot - SLOT_OFFSET) != module_id_q) begin
          out_d.error_code = ERR_MODULE;
        end else if ({9'd0, hlen_w} > elen_w) begin
          out_d.error_code = ERR_SAMPLE_COUNT;
        end else begin
          disc_d    = 1'b0;
          total_d   = total_w[PosW-1:0];
          elen_d    = elen_w;
          hlen_d    = hlen_w;
          pos_d     = (FirstRecWord + 1'b1 >= total_w[PosW-1:0]) ? '0 : FirstRecWord + 1'b1;
          // offset one word into the first record
          roff_d    = (elen_w == 14'd1) ? 14'd0 : 14'd1;
          rec_d     = (elen_w == 14'd1) ? 3'd1 : 3'd0;
          out_d.kind      = KIND_HIT;
          out_d.channel   = fw_q[0][3:0];
          out_d.raw_clock = raw;
          out_d.time_ps   = time_ps;
          out_d.energy    = fw_q[3][14:0];
          out_d.pileup    = {cfd_format_q & fw_q[2][31], fw_q[0][31]};
          out_d.cfd_raw   = cfd;
        end
      end else begin
        // channel record words: gates or sample pairs
        if (elen_q != '0 && rec_q < RecCount) begin
          out_d.channel     = fw_q[0][3:0];
          out_d.sub_channel = rec_q[1:0];
          out_d.payload     = in_i.payload.word;
          if (hlen_q == GATE_HEADER_LEN && roff_q >= GATE_FIRST_WORD && roff_q < GateEnd) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_GATE;
            out_d.item_index = 13'(roff_q - GATE_FIRST_WORD);
          end else if (roff_q >= {9'd0, hlen_q}) begin
            out_valid_d      = 1'b1;
            out_d.kind       = KIND_SAMPLE;
            out_d.item_index = 13'(roff_q - {9'd0, hlen_q});
          end else begin
            out_d = '0;
          end
        end
        // advance record offset and record number
        if (roff_inc == elen_q) begin
          roff_d = '0;
          if (rec_q < RecCount) begin
            rec_d = rec_q + 3'd1;
          end
        end else begin
          roff_d = roff_inc;
        end
        pos_d = (pos_inc >= {1'b0, total_q}) ? '0 : pos_inc[PosW-1:0];
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      total_q     <= '0;
      elen_q      <= '0;
      hlen_q      <= '0;
      roff_q      <= '0;
      rec_q       <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      total_q     <= total_d;
      elen_q      <= elen_d;
      hlen_q      <= hlen_d;
      roff_q      <= roff_d;
      rec_q       <= rec_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture summed header words and the result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept && !disc_q && pos_q < FirstRecWord) begin
      fw_q[pos_q[1:0]] <= in_i.payload.word;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/per_checker.sv
// ----------------------------------------------------------------------------
// per_checker
// Port-level assertions for the pulse event record parser, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module per_checker
  import per_pkg::*;
#(
  parameter int unsigned GATES_PER_RECORD = 8
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  // Block new words while the result register is full
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("word taken while result register full");

  // Error results carry only the error code
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_item.kind == KIND_ERROR |->
      out_item.channel == '0 && out_item.payload == '0 && out_item.time_ps == '0)
    else $error("error result carries stray fields");

  // Gate indexes stay within the gate block
  a_gate_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_item.kind == KIND_GATE |->
      out_item.item_index < 13'(GATES_PER_RECORD))
    else $error("gate index out of range");

endmodule

bind pulse_event_record_parser per_checker #(
  .GATES_PER_RECORD(GATES_PER_RECORD)
) u_per_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_item (out_o.payload)
);

`default_nettype wire

>>> tb/per_record_checker.sv
// ----------------------------------------------------------------------------
// per_record_checker
// Watches the word, result and configuration channels of the pulse event
// record parser. Keeps its own copy of the parser state and registers,
// predicts the result of every accepted word and compares each accepted
// result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module per_record_checker
  import per_pkg::*;
#(
  parameter int unsigned MaxEventWords  = 5000,
  parameter int unsigned GatesPerRecord = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  per_in_if         words_i,
  per_out_if        records_i,
  per_cfg_if        cfg_i,
  output int        mismatch_count_o,
  output int        pending_o,
  output logic      at_boundary_o,
  output int        hit_count_o,
  output int        gate_count_o,
  output int        sample_count_o,
  output int        error_count_o
);

  localparam int unsigned MaxReports = 10;

  // Register copies
  logic [3:0]  module_id_q;
  logic [14:0] ps_per_clock_q;
  logic        cfd_format_q;

  // Parser state copies
  logic [12:0] word_pos_q;
  logic [12:0] event_words_q;
  logic [13:0] rec_len_q;
  logic [4:0]  rec_hdr_len_q;
  logic [31:0] hdr_words_q [4];
  logic        dropping_q;

  out_item_t predicted_records [$];

  function automatic string record_text(out_item_t r);
    return $sformatf({"kind=%0d ch=%0d raw=%h ps=%h energy=%0d pileup=%0d",
                      " cfd=%h sub=%0d idx=%0d data=%h err=%0d"},
                     r.kind, r.channel, r.raw_clock, r.time_ps, r.energy,
                     r.pileup, r.cfd_raw, r.sub_channel, r.item_index,
                     r.payload, r.error_code);
  endfunction

  // Count a failure; show details for the first few only
  task automatic report_mismatch(string why, string want, out_item_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= MaxReports) begin
      $display("[%0t] result mismatch:%s", $time, why);
      $display("  expected %s", want);
      $display("  actual   %s", record_text(got));
    end
  endtask

  // Compare one accepted result against the oldest prediction
  task automatic check_record(out_item_t got);
    out_item_t want;
    string     diffs;
    case (got.kind)
      KIND_HIT:    hit_count_o++;
      KIND_GATE:   gate_count_o++;
      KIND_SAMPLE: sample_count_o++;
      default:     error_count_o++;
    endcase
    if (predicted_records.size() == 0) begin
      report_mismatch(" result with nothing outstanding", "nothing", got);
    end else begin
      want  = predicted_records.pop_front();
      diffs = "";
      if (got.kind !== want.kind) diffs = {diffs, " kind"};
      if (got.channel !== want.channel) diffs = {diffs, " channel"};
      if (got.raw_clock !== want.raw_clock) diffs = {diffs, " raw_clock"};
      if (got.time_ps !== want.time_ps) diffs = {diffs, " time_ps"};
      if (got.energy !== want.energy) diffs = {diffs, " energy"};
      if (got.pileup !== want.pileup) diffs = {diffs, " pileup"};
      if (got.cfd_raw !== want.cfd_raw) diffs = {diffs, " cfd_raw"};
      if (got.sub_channel !== want.sub_channel) diffs = {diffs, " sub_channel"};
      if (got.item_index !== want.item_index) diffs = {diffs, " item_index"};
      if (got.payload !== want.payload) diffs = {diffs, " payload"};
      if (got.error_code !== want.error_code) diffs = {diffs, " error_code"};
      if (diffs != "") report_mismatch(diffs, record_text(want), got);
    end
  endtask

  // Advance the parser copy by one word and queue the result it causes
  task automatic parse_word(logic [31:0] w, logic last);
    out_item_t   rec;
    logic        emit;
    logic        bad;
    err_e        code;
    logic [13:0] blen;
    logic [13:0] elen;
    logic [4:0]  hlen;
    logic [3:0]  slot;
    logic [15:0] cfd;
    logic [1:0]  pile;
    logic [63:0] raw;
    logic [63:0] fine;
    int unsigned total;
    int unsigned off;
    int unsigned k;
    int unsigned r;
    rec  = '0;
    emit = 1'b0;
    bad  = 1'b0;
    code = ERR_TOO_LONG;
    if (dropping_q) begin
      // Drop everything up to the end of the packet
      if (last) begin
        dropping_q = 1'b0;
        word_pos_q = '0;
      end
    end else if (word_pos_q < SummedHeaderLen) begin
      hdr_words_q[word_pos_q[1:0]] = w;
      word_pos_q = word_pos_q + 13'd1;
    end else if (word_pos_q == SummedHeaderLen) begin
      // First channel record word: check the event, then emit the hit or an error
      blen  = hdr_words_q[0][30:17];
      elen  = w[30:17];
      hlen  = w[16:12];
      slot  = hdr_words_q[0][7:4];
      total = blen + 4 * elen;
      if (total > MaxEventWords) begin
        bad  = 1'b1;
        code = ERR_TOO_LONG;
      end else if (blen < SummedHeaderLen || elen == 0 || hlen == 0) begin
        bad  = 1'b1;
        code = ERR_TOO_SHORT;
      end else if (slot < SLOT_OFFSET || slot - SLOT_OFFSET != module_id_q) begin
        bad  = 1'b1;
        code = ERR_MODULE;
      end else if (hlen > elen) begin
        bad  = 1'b1;
        code = ERR_SAMPLE_COUNT;
      end
      emit = 1'b1;
      if (bad) begin
        rec.kind       = KIND_ERROR;
        rec.error_code = code;
        word_pos_q     = '0;
        dropping_q     = !last;
      end else begin
        event_words_q = total[12:0];
        rec_len_q     = elen;
        rec_hdr_len_q = hlen;
        word_pos_q    = 13'd5;
        raw  = {16'h0, hdr_words_q[2][15:0], hdr_words_q[1]};
        pile = {1'b0, hdr_words_q[0][31]};
        if (!cfd_format_q) begin
          cfd  = hdr_words_q[2][31:16];
          fine = (64'(cfd) * 64'(ps_per_clock_q)) >> 16;
        end else begin
          cfd  = {1'b0, hdr_words_q[2][30:16]};
          fine = (64'(cfd) * 64'(ps_per_clock_q)) >> 15;
          pile[1] = hdr_words_q[2][31];
        end
        if (ps_per_clock_q == PS_DOUBLE_CLOCK) raw = raw << 1;
        rec.kind      = KIND_HIT;
        rec.channel   = hdr_words_q[0][3:0];
        rec.raw_clock = raw[48:0];
        rec.time_ps   = raw * 64'(ps_per_clock_q) + fine;
        rec.energy    = hdr_words_q[3][14:0];
        rec.pileup    = pile;
        rec.cfd_raw   = cfd;
        if (word_pos_q >= event_words_q) word_pos_q = '0;
      end
    end else begin
      // Record body: gate words, then sample pairs; trailing words are silent
      off = word_pos_q - SummedHeaderLen;
      if (rec_len_q != 0 && off < 4 * rec_len_q) begin
        k = off / rec_len_q;
        r = off % rec_len_q;
        if (rec_hdr_len_q == GATE_HEADER_LEN && r >= GATE_FIRST_WORD &&
            r < GATE_FIRST_WORD + GatesPerRecord) begin
          emit            = 1'b1;
          rec.kind        = KIND_GATE;
          rec.item_index  = 13'(r - GATE_FIRST_WORD);
        end else if (r >= rec_hdr_len_q) begin
          emit            = 1'b1;
          rec.kind        = KIND_SAMPLE;
          rec.item_index  = 13'(r - rec_hdr_len_q);
        end
        rec.channel     = emit ? hdr_words_q[0][3:0] : 4'd0;
        rec.sub_channel = emit ? k[1:0] : 2'd0;
        rec.payload     = emit ? w : 32'd0;
      end
      if (32'(word_pos_q) + 1 >= event_words_q) word_pos_q = '0;
      else word_pos_q = word_pos_q + 13'd1;
    end
    if (emit) predicted_records.push_back(rec);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_id_q    = MODULE_ID_RST;
      ps_per_clock_q = PS_PER_CLOCK_RST;
      cfd_format_q   = CFD_FORMAT_RST;
      word_pos_q     = '0;
      event_words_q  = '0;
      rec_len_q      = '0;
      rec_hdr_len_q  = '0;
      dropping_q     = 1'b0;
      for (int i = 0; i < 4; i++) hdr_words_q[i] = '0;
      predicted_records.delete();
      mismatch_count_o = 0;
      hit_count_o      = 0;
      gate_count_o     = 0;
      sample_count_o   = 0;
      error_count_o    = 0;
    end else begin
      // Results first: a result never belongs to a word taken at the same edge
      if (records_i.valid && records_i.ready) check_record(records_i.payload);
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.payload.index)
          CFG_MODULE_ID:    module_id_q    = cfg_i.payload.data[3:0];
          CFG_PS_PER_CLOCK: ps_per_clock_q = cfg_i.payload.data[14:0];
          CFG_CFD_FORMAT:   cfd_format_q   = cfg_i.payload.data[0];
          default: ;
        endcase
      end
      if (words_i.valid && words_i.ready) begin
        parse_word(words_i.payload.word, words_i.payload.last_in_packet);
      end
    end
    pending_o     = predicted_records.size();
    at_boundary_o = (word_pos_q == 0) && !dropping_q;
  end

endmodule

`default_nettype wire

>>> tb/pulse_event_record_parser_test.sv
// ----------------------------------------------------------------------------
// pulse_event_record_parser_test
// Drives the pulse event record parser with directed and random event
// streams under several register settings, with random gaps on the word
// channel and random stalls on the result channel. A checker beside the
// parser predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_event_record_parser_test;
  import per_pkg::*;

  localparam int unsigned MaxEventWords  = 5000;
  localparam int unsigned GatesPerRecord = 8;
  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned WordsPerPhase  = 260;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  per_in_if  words_if ();
  per_out_if records_if ();
  per_cfg_if cfg_if ();

  int   mismatches;
  int   pending;
  logic at_boundary;
  int   hits;
  int   gates;
  int   samples;
  int   errors;

  logic word_taken;
  logic cfg_taken;
  int   quiet_cycles;
  int   words_sent;
  int   settings_used;
  logic gaps_on;
  logic [3:0] cur_module;

  pulse_event_record_parser #(
    .MAX_EVENT_WORDS (MaxEventWords),
    .GATES_PER_RECORD(GatesPerRecord)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (words_if),
    .out_o (records_if),
    .cfg_i (cfg_if)
  );

  per_record_checker #(
    .MaxEventWords (MaxEventWords),
    .GatesPerRecord(GatesPerRecord)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .words_i         (words_if),
    .records_i       (records_if),
    .cfg_i           (cfg_if),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .at_boundary_o   (at_boundary),
    .hit_count_o     (hits),
    .gate_count_o    (gates),
    .sample_count_o  (samples),
    .error_count_o   (errors)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Latch handshakes at the edge; end the run if nothing moves for too long
  always @(posedge clk) begin
    word_taken <= words_if.valid && words_if.ready;
    cfg_taken  <= cfg_if.valid && cfg_if.ready;
    if (!rst_n || (words_if.valid && words_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (records_if.valid && records_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: short and long stalls between runs of ready, some runs long
  initial begin
    int n;
    records_if.ready <= 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          records_if.ready <= 1'b0;
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        end
        9: begin
          records_if.ready <= 1'b1;
          n = $urandom_range(100, 400);
        end
        default: begin
          records_if.ready <= 1'b1;
          n = $urandom_range(1, 10);
        end
      endcase
      repeat (n) @(negedge clk);
    end
  end

  function automatic logic rand_last();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic logic [31:0] summed_word(logic finish, int unsigned blen,
                                              int unsigned slot, int unsigned chan);
    return {finish, 14'(blen), 9'($urandom), 4'(slot), 4'(chan)};
  endfunction

  function automatic logic [31:0] record_word(int unsigned elen, int unsigned hlen);
    return {1'($urandom), 14'(elen), 5'(hlen), 12'($urandom)};
  endfunction

  // Hand one word over; hold valid high when the next word follows at once
  task automatic send_word(logic [31:0] w, logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      words_if.valid <= 1'b0;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    words_if.valid                  <= 1'b1;
    words_if.payload.word           <= w;
    words_if.payload.last_in_packet <= last;
    @(negedge clk);
    while (!word_taken) @(negedge clk);
    words_sent++;
  endtask

  // Feed filler until the parser sits at an event boundary
  task automatic realign();
    while (!at_boundary) send_word($urandom, 1'b1);
  endtask

  // Wait until every result is in and in-flight words have settled
  task automatic wait_idle();
    words_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Five leading words, then a body; a closing body ends the packet on its last word
  task automatic send_event(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3, logic [31:0] w4, logic last4,
                            int unsigned body, logic close);
    realign();
    send_word(w0, rand_last());
    send_word(w1, rand_last());
    send_word(w2, rand_last());
    send_word(w3, rand_last());
    send_word(w4, last4);
    for (int unsigned i = 0; i < body; i++) begin
      send_word($urandom, close ? (i == body - 1) : rand_last());
    end
  endtask

  task automatic send_good_event(int unsigned blen, int unsigned elen, int unsigned hlen,
                                 logic [31:0] w1, logic [31:0] w2, logic [31:0] w3,
                                 logic finish, int unsigned chan);
    send_event(summed_word(finish, blen, cur_module + SLOT_OFFSET, chan), w1, w2, w3,
               record_word(elen, hlen), rand_last(), blen + 4 * elen - 5, 1'b0);
  endtask

  // An event that fails at its fifth word; drop the rest of the packet after it
  task automatic send_bad_event(logic [31:0] w0, logic [31:0] w4, logic last4);
    send_event(w0, $urandom, $urandom, $urandom, w4, last4,
               last4 ? 0 : $urandom_range(1, 5), 1'b1);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= idx;
    cfg_if.payload.data  <= data;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
  endtask

  // Write all three registers; unused data bits carry random values
  task automatic apply_setting(logic [3:0] module_id, logic [14:0] ps, logic fmt);
    write_register(CFG_MODULE_ID, {12'($urandom), module_id});
    write_register(CFG_PS_PER_CLOCK, {1'($urandom), ps});
    write_register(CFG_CFD_FORMAT, {15'($urandom), fmt});
    cfg_if.valid <= 1'b0;
    cur_module = module_id;
    settings_used++;
  endtask

  task automatic random_good_event();
    int unsigned blen;
    int unsigned elen;
    int unsigned hlen;
    blen = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : 4;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        elen = $urandom_range(11, 20);
        hlen = GATE_HEADER_LEN;
      end
      9: begin
        elen = $urandom_range(31, 80);
        hlen = $urandom_range(1, 31);
      end
      default: begin
        elen = $urandom_range(1, 12);
        hlen = $urandom_range(1, elen);
      end
    endcase
    send_good_event(blen, elen, hlen, $urandom, $urandom, $urandom, 1'($urandom),
                    $urandom_range(0, 15));
  endtask

  task automatic random_bad_event();
    err_e        code;
    int unsigned elen;
    int unsigned slot;
    code = err_e'($urandom_range(0, 3));
    case (code)
      ERR_TOO_LONG: begin
        send_bad_event(summed_word(1'($urandom), $urandom_range(4, 16383),
                                   $urandom_range(0, 15), $urandom_range(0, 15)),
                       record_word($urandom_range(1250, 16383), $urandom_range(0, 31)),
                       rand_last());
      end
      ERR_TOO_SHORT: begin
        elen = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
          0: send_bad_event(summed_word(1'($urandom), $urandom_range(0, 3),
                                        $urandom_range(0, 15), $urandom_range(0, 15)),
                            record_word(elen, $urandom_range(1, elen)), rand_last());
          1: send_bad_event(summed_word(1'($urandom), 4, $urandom_range(0, 15),
                                        $urandom_range(0, 15)),
                            record_word(0, $urandom_range(0, 31)), rand_last());
          default: send_bad_event(summed_word(1'($urandom), 4, $urandom_range(0, 15),
                                              $urandom_range(0, 15)),
                                  record_word(elen, 0), rand_last());
        endcase
      end
      ERR_MODULE: begin
        do slot = $urandom_range(0, 15); while (slot == cur_module + SLOT_OFFSET);
        elen = $urandom_range(1, 12);
        send_bad_event(summed_word(1'($urandom), 4, slot, $urandom_range(0, 15)),
                       record_word(elen, $urandom_range(1, elen)), rand_last());
      end
      default: begin
        elen = $urandom_range(1, 30);
        send_bad_event(summed_word(1'($urandom), 4, cur_module + SLOT_OFFSET,
                                   $urandom_range(0, 15)),
                       record_word(elen, $urandom_range(elen + 1, 31)), rand_last());
      end
    endcase
  endtask

  // Mostly well-formed events, some broken ones, a little raw noise
  task automatic random_event();
    int unsigned pick;
    gaps_on = ($urandom_range(0, 3) != 0);
    pick    = $urandom_range(0, 19);
    if (pick < 14) begin
      random_good_event();
    end else if (pick < 18) begin
      random_bad_event();
    end else begin
      send_event($urandom, $urandom, $urandom, $urandom, $urandom, rand_last(),
                 $urandom_range(0, 6), 1'b0);
    end
  endtask

  task automatic directed_events();
    // Reset settings: module 0, 10000 ps per clock, 15-bit fraction
    send_good_event(4, 4, 2, '0, '0, '0, 1'b0, 0);
    send_good_event(4, 3, 3, '1, '1, '1, 1'b1, 15);
    send_good_event(4, 12, GATE_HEADER_LEN, $urandom, $urandom, $urandom, 1'b0, 7);
    // Extra summed-header words at the end of the event
    send_good_event(7, 2, 1, $urandom, $urandom, $urandom, 1'b1, 3);
    // Long records behind the longest record header
    send_good_event(4, 40, 31, $urandom, $urandom, $urandom, 1'b0, 9);
    // Too long, at the field maxima and just over the limit
    send_bad_event(summed_word(1'b1, 16383, 15, 15), record_word(16383, 31), 1'b0);
    send_bad_event(summed_word(1'b0, 5, 2, 4), record_word(1249, 1), 1'b1);
    // Too short: summed length, record length, record header length
    send_bad_event(summed_word(1'b0, 3, 2, 1), record_word(4, 2), 1'b1);
    send_bad_event(summed_word(1'b0, 4, 2, 1), record_word(0, 2), 1'b0);
    send_bad_event(summed_word(1'b0, 4, 2, 1), record_word(4, 0), 1'b0);
    // Module mismatch: slot below the offset, and a wrong slot
    send_bad_event(summed_word(1'b0, 4, 0, 2), record_word(4, 2), 1'b0);
    send_bad_event(summed_word(1'b0, 4, 1, 2), record_word(4, 2), 1'b1);
    send_bad_event(summed_word(1'b0, 4, 5, 2), record_word(4, 2), 1'b0);
    // Record header longer than the record
    send_bad_event(summed_word(1'b0, 4, 2, 6), record_word(30, 31), 1'b0);

    // Top module, slowest clock, 16-bit fraction
    wait_idle();
    apply_setting(4'd13, 15'd20000, 1'b0);
    send_good_event(4, 2, 1, '1, '1, '1, 1'b1, 15);
    send_bad_event(summed_word(1'b0, 4, 14, 0), record_word(4, 2), 1'b0);
    send_good_event(4, 11, GATE_HEADER_LEN, $urandom, $urandom, $urandom, 1'b0, 0);

    // Fastest clock setting
    wait_idle();
    apply_setting(4'd0, 15'd1, 1'b1);
    send_good_event(4, 2, 1, '1, '1, '1, 1'b0, 1);

    // Doubled raw clock in both fraction formats
    wait_idle();
    apply_setting(4'd6, PS_DOUBLE_CLOCK, 1'b0);
    send_good_event(4, 2, 2, '1, '1, '1, 1'b1, 8);
    wait_idle();
    apply_setting(4'd9, PS_DOUBLE_CLOCK, 1'b1);
    send_good_event(4, 2, 2, '1, '1, '1, 1'b0, 8);
  endtask

  initial begin
    int unsigned stop_at;
    logic [14:0] ps;
    words_if.valid   <= 1'b0;
    words_if.payload <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.payload   <= '0;
    words_sent    = 0;
    settings_used = 1;
    gaps_on       = 1'b1;
    cur_module    = MODULE_ID_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_events();

    for (int p = 0; p < RandomPhases; p++) begin
      realign();
      wait_idle();
      case ($urandom_range(0, 4))
        0: ps = 15'd1;
        1: ps = 15'd20000;
        2: ps = PS_DOUBLE_CLOCK;
        default: ps = 15'($urandom_range(1, 20000));
      endcase
      apply_setting(4'($urandom_range(0, 13)), ps, 1'($urandom));
      stop_at = words_sent + WordsPerPhase;
      while (words_sent < stop_at) random_event();
    end

    realign();
    wait_idle();
    $display("Run covered %0d words under %0d register settings.", words_sent, settings_used);
    $display("Results seen: %0d hits, %0d gate words, %0d sample pairs, %0d errors.",
             hits, gates, samples, errors);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
